FILE: design/scu_pkg.sv
// Shared types and constants for the selection count unit.
package scu_pkg;

    localparam int ACC_W     = 64;
    localparam int FACTOR_W  = 9;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

endpackage

FILE: design/selection_count_unit.sv
// Top level of the selection count unit: sequencer, shared multiplier and serial divider.

// The unit counts the ways to fill k slots from n symbols: n^k with no flag
// set, the falling factorial with distinct, C(n+k-1,k) with nondecreasing and
// C(n,k) with both; k is saturated to MAX_SLOTS. The count is built in one
// 64-bit accumulator that is multiplied by one factor per slot; for the binomial
// modes each multiply is followed by an exact division by the step number in a
// restoring divider that produces one quotient bit per cycle and runs over all
// 64 accumulator bits for each slot. One item is worked on at a time; a new item
// is taken while the previous result still waits in the output register.
module selection_count_unit #(
    parameter int MAX_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] symbol_count, [11:8] slot_count, zero fill above
    input  logic [1:0]  s_tuser,   // [0] nondecreasing, [1] distinct
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] selection_count
);

    localparam int CW = $clog2(MAX_SLOTS + 1);

    scu_pkg::state_t state_reg, state_next;

    logic [scu_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [scu_pkg::FACTOR_W-1:0]  base_reg, base_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [CW-1:0]                 step_reg, step_next;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic [scu_pkg::DIV_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                          dec_reg, dec_next;
    logic                          div_en_reg, div_en_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [scu_pkg::ACC_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [7:0]                    in_n;
    logic [3:0]                    in_k;
    logic                          in_nondec;
    logic                          in_dist;
    logic [CW-1:0]                 k_sat;
    logic                          k_gt_n;
    logic                          in_zero;

    logic [CW-1:0]                 step_inc;
    logic [CW-1:0]                 divisor;
    logic [scu_pkg::FACTOR_W-1:0]  factor;
    logic [scu_pkg::ACC_W+scu_pkg::FACTOR_W-1:0] product;
    logic [CW:0]                   rem_shift;
    logic                          quo_bit;

    assign in_n      = s_tdata[7:0];
    assign in_k      = s_tdata[11:8];
    assign in_nondec = s_tuser[0];
    assign in_dist   = s_tuser[1];

    assign k_sat  = (in_k > 4'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(in_k);
    assign k_gt_n = 8'(k_sat) > in_n;

    // Distinct selections need k <= n; nondecreasing ones with no symbols
    // are empty as soon as there is a slot.
    assign in_zero = (in_dist && k_gt_n) || (in_nondec && !in_dist && in_n == 8'd0
                     && k_sat != '0);

    assign step_inc = step_reg + CW'(1);
    assign divisor  = step_inc;
    assign factor   = dec_reg ? (base_reg - scu_pkg::FACTOR_W'(step_reg)) : base_reg;
    assign product  = acc_reg * factor;

    assign rem_shift = {rem_reg, acc_reg[scu_pkg::ACC_W-1]};
    assign quo_bit   = rem_shift >= {1'b0, divisor};

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        bit_cnt_next  = bit_cnt_reg;
        dec_next      = dec_reg;
        div_en_next   = div_en_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            scu_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    acc_next    = in_zero ? '0 : scu_pkg::ACC_W'(1);
                    k_next      = k_sat;
                    step_next   = '0;
                    dec_next    = in_nondec || in_dist;
                    div_en_next = in_nondec;
                    if (in_nondec && !in_dist) begin
                        base_next = scu_pkg::FACTOR_W'(in_n) + scu_pkg::FACTOR_W'(k_sat)
                                    - scu_pkg::FACTOR_W'(1);
                    end else begin
                        base_next = scu_pkg::FACTOR_W'(in_n);
                    end
                    if (in_zero || k_sat == '0) begin
                        state_next = scu_pkg::ST_HOLD;
                    end else begin
                        state_next = scu_pkg::ST_MUL;
                    end
                end
            end
            scu_pkg::ST_MUL: begin
                acc_next = product[scu_pkg::ACC_W-1:0];
                if (div_en_reg) begin
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = scu_pkg::ST_DIV;
                end else begin
                    step_next  = step_inc;
                    state_next = (step_inc == k_reg) ? scu_pkg::ST_HOLD : scu_pkg::ST_MUL;
                end
            end
            scu_pkg::ST_DIV: begin
                // Restoring division: the dividend shifts out of the top of the
                // accumulator while quotient bits shift in at the bottom.
                acc_next     = {acc_reg[scu_pkg::ACC_W-2:0], quo_bit};
                rem_next     = quo_bit ? CW'(rem_shift - {1'b0, divisor}) : CW'(rem_shift);
                bit_cnt_next = bit_cnt_reg + scu_pkg::DIV_CNT_W'(1);
                if (bit_cnt_reg == scu_pkg::DIV_LAST) begin
                    step_next  = step_inc;
                    state_next = (step_inc == k_reg) ? scu_pkg::ST_HOLD : scu_pkg::ST_MUL;
                end
            end
            scu_pkg::ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg;
                    state_next    = scu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= scu_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        k_reg       <= k_next;
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        dec_reg     <= dec_next;
        div_en_reg  <= div_en_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == scu_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the selection count unit, with a directed table and random traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_SLOTS    = 8;
    localparam int ITEM_CYCLES  = 65 * MAX_SLOTS + 2;
    localparam int N_RANDOM     = 500;
    localparam int N_DIRECTED   = 25;
    localparam int LIMIT_CYCLES = 4 * (N_RANDOM + N_DIRECTED) * (ITEM_CYCLES + 100) + 1000;

    typedef struct {
        logic [7:0]  n;
        logic [3:0]  k;
        logic        nondec;
        logic        distinct;
        logic [63:0] count;
    } selection_t;

    typedef struct {
        logic [7:0]  n;
        logic [3:0]  k;
        logic        nondec;
        logic        distinct;
        bit          typed;
        logic [63:0] count;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] symbol_count, [11:8] slot_count, zero fill above
    logic [1:0]  s_tuser;   // [0] nondecreasing, [1] distinct
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] selection_count

    selection_t   count_q[$];
    int           mismatches = 0;
    int           cycles = 0;
    int           ready_mode = 0;
    int           ready_run = 0;
    int           burst_left = 0;

    directed_row_t directed_rows[N_DIRECTED] = '{
        '{8'd255, 4'd8,  1'b0, 1'b0, 1'b0, 64'd0},
        '{8'd255, 4'd8,  1'b0, 1'b1, 1'b0, 64'd0},
        '{8'd255, 4'd8,  1'b1, 1'b0, 1'b0, 64'd0},
        '{8'd255, 4'd8,  1'b1, 1'b1, 1'b0, 64'd0},
        '{8'd1,   4'd1,  1'b0, 1'b0, 1'b1, 64'd1},
        '{8'd1,   4'd1,  1'b0, 1'b1, 1'b1, 64'd1},
        '{8'd1,   4'd1,  1'b1, 1'b0, 1'b1, 64'd1},
        '{8'd1,   4'd1,  1'b1, 1'b1, 1'b1, 64'd1},
        // With no slots only the empty selection exists.
        '{8'd0,   4'd0,  1'b0, 1'b0, 1'b1, 64'd1},
        '{8'd3,   4'd0,  1'b0, 1'b1, 1'b1, 64'd1},
        '{8'd5,   4'd0,  1'b1, 1'b0, 1'b1, 64'd1},
        '{8'd200, 4'd0,  1'b1, 1'b1, 1'b1, 64'd1},
        // No symbols but at least one slot.
        '{8'd0,   4'd3,  1'b0, 1'b0, 1'b1, 64'd0},
        '{8'd0,   4'd8,  1'b0, 1'b1, 1'b1, 64'd0},
        '{8'd0,   4'd5,  1'b1, 1'b0, 1'b1, 64'd0},
        '{8'd0,   4'd1,  1'b1, 1'b1, 1'b1, 64'd0},
        // Slot counts above the maximum are saturated.
        '{8'd255, 4'd15, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'd200, 4'd12, 1'b1, 1'b1, 1'b0, 64'd0},
        '{8'd9,   4'd9,  1'b1, 1'b0, 1'b0, 64'd0},
        // Distinct selections with more slots than symbols or exactly as many, then two large computed counts.
        '{8'd3,   4'd5,  1'b0, 1'b1, 1'b1, 64'd0},
        '{8'd7,   4'd8,  1'b1, 1'b1, 1'b1, 64'd0},
        '{8'd8,   4'd8,  1'b0, 1'b1, 1'b1, 64'd40320},
        '{8'd8,   4'd8,  1'b1, 1'b1, 1'b1, 64'd1},
        '{8'd170, 4'd7,  1'b1, 1'b0, 1'b0, 64'd0},
        '{8'd85,  4'd6,  1'b0, 1'b1, 1'b0, 64'd0}
    };

    selection_count_unit #(
        .MAX_SLOTS(MAX_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Exact C(m, r), built by multiplying and dividing in turn so that every
    // partial value stays an integer.
    function automatic logic [63:0] choose(input logic [63:0] m, input logic [63:0] r);
        logic [63:0] acc;
        acc = 64'd1;
        if (r > m) begin
            return 64'd0;
        end
        for (logic [63:0] i = 0; i < r; i++) begin
            acc = acc * (m - i);
            acc = acc / (i + 64'd1);
        end
        return acc;
    endfunction

    function automatic logic [63:0] count_selections(input logic [7:0] n_in,
                                                     input logic [3:0] k_in,
                                                     input logic nondec,
                                                     input logic distinct);
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] acc;
        n = 64'(n_in);
        k = (k_in > MAX_SLOTS) ? 64'(MAX_SLOTS) : 64'(k_in);
        acc = 64'd1;
        if (!nondec && !distinct) begin
            for (int i = 0; i < k; i++) begin
                acc = acc * n;
            end
        end else if (!nondec && distinct) begin
            if (k > n) begin
                acc = 64'd0;
            end else begin
                for (logic [63:0] i = 0; i < k; i++) begin
                    acc = acc * (n - i);
                end
            end
        end else if (nondec && !distinct) begin
            if (k == 0) begin
                acc = 64'd1;
            end else if (n == 0) begin
                acc = 64'd0;
            end else begin
                acc = choose(n + k - 64'd1, k);
            end
        end else begin
            acc = choose(n, k);
        end
        return acc;
    endfunction

    // Presents one item, holds it until the transfer, then files the expectation.
    task automatic send_item(input logic [7:0] n, input logic [3:0] k, input logic nondec,
                             input logic distinct, input bit typed,
                             input logic [63:0] typed_count);
        selection_t item;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(13, 40);
            end else begin
                gap = $urandom_range(1, 12);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, k, n};
        s_tuser  <= {distinct, nondec};
        do @(posedge aclk); while (!s_tready);
        item.n        = n;
        item.k        = k;
        item.nondec   = nondec;
        item.distinct = distinct;
        item.count    = typed ? typed_count : count_selections(n, k, nondec, distinct);
        count_q.insert(count_q.size(), item);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver alternates between always ready, coin-flip ready and long stalls.
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_run  = $urandom_range(5, 60);
        end
        ready_run--;
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        selection_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (count_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result transfer: selection_count=%0d", m_tdata);
                end
            end else begin
                want = count_q.pop_front();
                if (m_tdata !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch n=%0d k=%0d nondec=%0b distinct=%0b: expected %0d, got %0d",
                                 want.n, want.k, want.nondec, want.distinct, want.count, m_tdata);
                    end
                end
            end
        end
    end

    initial begin
        logic [7:0] n;
        logic [3:0] k;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].n, directed_rows[i].k, directed_rows[i].nondec,
                      directed_rows[i].distinct, directed_rows[i].typed,
                      directed_rows[i].count);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // Small symbol counts make distinct selections with too many slots common.
            case ($urandom_range(0, 15))
                0:       n = 8'd0;
                1, 2, 3: n = 8'($urandom_range(1, 10));
                default: n = 8'($urandom_range(1, 255));
            endcase
            if ($urandom_range(0, 9) == 0) begin
                k = 4'($urandom_range(0, 15));
            end else begin
                k = 4'($urandom_range(1, MAX_SLOTS));
            end
            send_item(n, k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 64'd0);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (count_q.size() != 0) @(posedge aclk);
        repeat (ITEM_CYCLES) @(posedge aclk);

        if (mismatches == 0 && count_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
